// ===== hdl/pop3d_pkg.sv =====
`timescale 1ns / 1ps

package pop3d_pkg;

   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_DOT = 8'd46;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_CONTENT = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   localparam logic [1:0] US_NONE   = 2'd0;
   localparam logic [1:0] US_PERIOD = 2'd1;
   localparam logic [1:0] US_CR     = 2'd2;

   localparam logic [2:0] STATUS_LEN_MAX = 3'd7;
   localparam logic [2:0] OK_LEN         = 3'd3;
   localparam logic [2:0] ERR_LEN        = 3'd4;

   typedef struct packed {
      logic       in_content;
      logic [2:0] status_len;
      logic       ok_prefix;
      logic       err_prefix;
      logic       status_saw_cr;
      logic [1:0] unstuff_state;
      logic       body_empty;
      logic       emitted_cr;
      logic       line_start;
      logic       held_cr;
   } state_type;

   localparam state_type STATE_RESET = '{
      in_content:    1'b0,
      status_len:    3'd0,
      ok_prefix:     1'b1,
      err_prefix:    1'b1,
      status_saw_cr: 1'b0,
      unstuff_state: US_NONE,
      body_empty:    1'b1,
      emitted_cr:    1'b0,
      line_start:    1'b0,
      held_cr:       1'b0
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic       response_ok;
      logic       last;
   } result_type;

   // "+OK"
   function automatic logic [7:0] ok_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'd43;
         2'd1: c = 8'd79;
         2'd2: c = 8'd75;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   // "-ERR"
   function automatic logic [7:0] err_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'd45;
         2'd1: c = 8'd69;
         2'd2: c = 8'd82;
         2'd3: c = 8'd82;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/pop3d_step.sv =====
`timescale 1ns / 1ps

module pop3d_step (
   input  pop3d_pkg::state_type  state,
   input  logic                  multiline_mode,
   input  logic [7:0]            in_byte,
   output pop3d_pkg::state_type  state_next,
   output pop3d_pkg::result_type res0,
   output pop3d_pkg::result_type res1,
   output logic [1:0]            res_count
);

   pop3d_pkg::state_type s;
   logic                 done;
   logic                 emit;

   always_comb begin
      s         = state;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;
      done      = 1'b0;
      emit      = 1'b0;

      if (!s.in_content) begin
         res0      = '{out_byte: in_byte, out_kind: pop3d_pkg::KIND_STATUS,
                       response_ok: 1'b0, last: 1'b0};
         res_count = 2'd1;
         if (s.status_len < pop3d_pkg::OK_LEN
               && in_byte != pop3d_pkg::ok_char(s.status_len[1:0])) begin
            s.ok_prefix = 1'b0;
         end
         if (s.status_len < pop3d_pkg::ERR_LEN
               && in_byte != pop3d_pkg::err_char(s.status_len[1:0])) begin
            s.err_prefix = 1'b0;
         end
         if (s.status_len < pop3d_pkg::STATUS_LEN_MAX) begin
            s.status_len = s.status_len + 3'd1;
         end
         if (in_byte == pop3d_pkg::CH_LF && s.status_saw_cr) begin
            if (!multiline_mode || s.err_prefix) begin
               res1      = '{out_byte: 8'd0, out_kind: pop3d_pkg::KIND_END,
                             response_ok: s.ok_prefix, last: 1'b1};
               res_count = 2'd2;
               s         = pop3d_pkg::STATE_RESET;
            end else begin
               s.in_content    = 1'b1;
               s.unstuff_state = pop3d_pkg::US_NONE;
               s.body_empty    = 1'b1;
               s.emitted_cr    = 1'b0;
               s.line_start    = 1'b0;
               s.held_cr       = 1'b0;
               s.status_saw_cr = 1'b0;
            end
         end else begin
            s.status_saw_cr = (in_byte == pop3d_pkg::CH_CR);
         end
      end else begin
         // withheld CR after a leading period
         if (s.held_cr) begin
            if (in_byte == pop3d_pkg::CH_LF) begin
               res0      = '{out_byte: 8'd0, out_kind: pop3d_pkg::KIND_END,
                             response_ok: s.ok_prefix, last: 1'b1};
               res_count = 2'd1;
               s         = pop3d_pkg::STATE_RESET;
               done      = 1'b1;
            end else begin
               res0            = '{out_byte: pop3d_pkg::CH_CR,
                                   out_kind: pop3d_pkg::KIND_CONTENT,
                                   response_ok: 1'b0, last: 1'b0};
               res_count       = 2'd1;
               s.line_start    = 1'b0;
               s.emitted_cr    = 1'b1;
               s.body_empty    = 1'b0;
               s.held_cr       = 1'b0;
               s.unstuff_state = pop3d_pkg::US_CR;
            end
         end

         if (!done) begin
            emit = 1'b1;
            priority if (in_byte == pop3d_pkg::CH_DOT) begin
               if (s.unstuff_state != pop3d_pkg::US_PERIOD
                     && (s.body_empty || s.line_start)) begin
                  s.unstuff_state = pop3d_pkg::US_PERIOD;
                  emit            = 1'b0;
               end else begin
                  s.unstuff_state = pop3d_pkg::US_NONE;
               end
            end else if (in_byte == pop3d_pkg::CH_CR) begin
               if (s.unstuff_state == pop3d_pkg::US_PERIOD) begin
                  s.unstuff_state = pop3d_pkg::US_CR;
                  s.held_cr       = 1'b1;
                  emit            = 1'b0;
               end else begin
                  s.unstuff_state = pop3d_pkg::US_NONE;
               end
            end else begin
               s.unstuff_state = pop3d_pkg::US_NONE;
            end

            if (emit) begin
               if (res_count == 2'd0) begin
                  res0 = '{out_byte: in_byte, out_kind: pop3d_pkg::KIND_CONTENT,
                           response_ok: 1'b0, last: 1'b0};
               end else begin
                  res1 = '{out_byte: in_byte, out_kind: pop3d_pkg::KIND_CONTENT,
                           response_ok: 1'b0, last: 1'b0};
               end
               res_count    = res_count + 2'd1;
               s.line_start = (in_byte == pop3d_pkg::CH_LF) && s.emitted_cr;
               s.emitted_cr = (in_byte == pop3d_pkg::CH_CR);
               s.body_empty = 1'b0;
            end
         end
      end

      state_next = s;
   end

endmodule

// ===== hdl/pop3d_outq.sv =====
`timescale 1ns / 1ps

// Four-entry result queue; takes up to two words per cycle, gives one while pop_ready is high.
module pop3d_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  pop3d_pkg::result_type push0,
   input  pop3d_pkg::result_type push1,
   output logic                  has_room,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pop3d_pkg::result_type pop_data
);

   localparam int DEPTH = 4;

   pop3d_pkg::result_type entry_ff [DEPTH];
   logic [1:0]            wr_ptr_ff, wr_ptr_in;
   logic [1:0]            rd_ptr_ff, rd_ptr_in;
   logic [2:0]            count_ff,  count_in;
   logic                  pop;
   logic [1:0]            wr_ptr_p1;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != 3'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= 3'(DEPTH - 2));
   assign wr_ptr_p1 = wr_ptr_ff + 2'd1;

   assign wr_ptr_in = wr_ptr_ff + push_count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_p1] <= push1;
      end
   end

endmodule

// ===== hdl/pop3_response_deframer_core.sv =====
`timescale 1ns / 1ps

// POP3 reply deframer with dot unstuffing.
// req_* takes one server byte per word; rsp_* gives result words: status
// bytes (kind 0), unstuffed content bytes (kind 1) and an end-of-reply
// marker (kind 2, last high, response_ok = status line began with "+OK").
// csr_wr_en/csr_wr_data set multiline_mode; it is looked at when the status
// line's CR LF arrives, and should be written between replies.
// Results of an accepted byte are written into the output queue at the edge
// that accepts it. A byte gives zero, one or two result words.
// Throughput: one byte per cycle while the receiver keeps up; the output
// queue (four words) is the limit, and req_ready drops while it holds more
// than two words, so a stalled receiver backs up to the sender with no loss.
// Reset clears the reply state, multiline_mode and the queue; the first byte
// after reset is not refused.
module pop3_response_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_response_ok,
   output logic       rsp_last
);

   pop3d_pkg::state_type  state_ff, state_in;
   logic                  mode_ff,  mode_in;
   pop3d_pkg::result_type res0, res1, rsp_word;
   logic [1:0]            res_count;
   logic [1:0]            push_count;
   logic                  accept;

   assign accept     = req_valid && req_ready;
   assign push_count = accept ? res_count : 2'd0;
   assign mode_in    = csr_wr_en ? csr_wr_data : mode_ff;

   pop3d_step u_step (
      .state          (state_ff),
      .multiline_mode (mode_ff),
      .in_byte        (req_in_byte),
      .state_next     (state_in),
      .res0           (res0),
      .res1           (res1),
      .res_count      (res_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pop3d_pkg::STATE_RESET;
         mode_ff  <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         mode_ff <= mode_in;
      end
   end

   pop3d_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .has_room   (req_ready),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_word)
   );

   assign rsp_out_byte    = rsp_word.out_byte;
   assign rsp_out_kind    = rsp_word.out_kind;
   assign rsp_response_ok = rsp_word.response_ok;
   assign rsp_last        = rsp_word.last;

endmodule

// ===== hdl/pop3d_checker.sv =====
`timescale 1ns / 1ps

module pop3d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_out_kind,
   input logic       rsp_response_ok,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_kind) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == pop3d_pkg::KIND_END
         |-> rsp_last && rsp_out_byte == 8'd0)
      else $error("end marker malformed");

   a_data_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != pop3d_pkg::KIND_END
         |-> !rsp_last && !rsp_response_ok)
      else $error("data word carries end flags");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind == pop3d_pkg::KIND_STATUS
         || rsp_out_kind == pop3d_pkg::KIND_CONTENT
         || rsp_out_kind == pop3d_pkg::KIND_END)
      else $error("bad rsp kind");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind pop3_response_deframer_core pop3d_checker u_pop3d_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_out_kind    (rsp_out_kind),
   .rsp_response_ok (rsp_response_ok),
   .rsp_last        (rsp_last)
);

// ===== test/pop3_deframe_checker.sv =====
`timescale 1ns / 1ps

module pop3_deframe_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_out_kind,
   input  logic       rsp_response_ok,
   input  logic       rsp_last,
   output int         mismatch_count,
   output int         words_pending
);

   pop3d_pkg::state_type  reply_st = pop3d_pkg::STATE_RESET;
   logic                  multiline = 1'b0;
   pop3d_pkg::result_type expected_words[$];
   int                    errors = 0;
   string                 ok_text = "+OK";
   string                 err_text = "-ERR";

   assign mismatch_count = errors;

   function automatic void expect_word(logic [7:0] b, logic [1:0] kind, logic ok,
                                       logic fin);
      pop3d_pkg::result_type w;
      w.out_byte    = b;
      w.out_kind    = kind;
      w.response_ok = ok;
      w.last        = fin;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void expect_content(logic [7:0] b);
      expect_word(b, pop3d_pkg::KIND_CONTENT, 1'b0, 1'b0);
      reply_st.line_start = (b == pop3d_pkg::CH_LF) && reply_st.emitted_cr;
      reply_st.emitted_cr = (b == pop3d_pkg::CH_CR);
      reply_st.body_empty = 1'b0;
   endfunction

   function automatic void expect_end();
      expect_word(8'd0, pop3d_pkg::KIND_END, reply_st.ok_prefix, 1'b1);
      reply_st = pop3d_pkg::STATE_RESET;
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      if (!reply_st.in_content) begin
         expect_word(b, pop3d_pkg::KIND_STATUS, 1'b0, 1'b0);
         if (reply_st.status_len < pop3d_pkg::OK_LEN
               && b != ok_text[reply_st.status_len])
            reply_st.ok_prefix = 1'b0;
         if (reply_st.status_len < pop3d_pkg::ERR_LEN
               && b != err_text[reply_st.status_len])
            reply_st.err_prefix = 1'b0;
         if (reply_st.status_len < pop3d_pkg::STATUS_LEN_MAX)
            reply_st.status_len = reply_st.status_len + 3'd1;
         if (b == pop3d_pkg::CH_LF && reply_st.status_saw_cr) begin
            if (!multiline || reply_st.err_prefix) begin
               expect_end();
               return;
            end
            reply_st.in_content    = 1'b1;
            reply_st.unstuff_state = pop3d_pkg::US_NONE;
            reply_st.body_empty    = 1'b1;
            reply_st.emitted_cr    = 1'b0;
            reply_st.line_start    = 1'b0;
            reply_st.held_cr       = 1'b0;
         end
         reply_st.status_saw_cr = (b == pop3d_pkg::CH_CR);
         return;
      end

      // withheld CR after a dropped period
      if (reply_st.held_cr) begin
         if (b == pop3d_pkg::CH_LF) begin
            expect_end();
            return;
         end
         expect_content(pop3d_pkg::CH_CR);
         reply_st.held_cr       = 1'b0;
         reply_st.unstuff_state = pop3d_pkg::US_CR;
      end

      if (b == pop3d_pkg::CH_DOT) begin
         if (reply_st.unstuff_state != pop3d_pkg::US_PERIOD &&
             (reply_st.body_empty || reply_st.line_start)) begin
            reply_st.unstuff_state = pop3d_pkg::US_PERIOD;
            return;
         end
         reply_st.unstuff_state = pop3d_pkg::US_NONE;
      end else if (b == pop3d_pkg::CH_CR) begin
         if (reply_st.unstuff_state == pop3d_pkg::US_PERIOD) begin
            reply_st.unstuff_state = pop3d_pkg::US_CR;
            reply_st.held_cr       = 1'b1;
            return;
         end
         reply_st.unstuff_state = pop3d_pkg::US_NONE;
      end else begin
         reply_st.unstuff_state = pop3d_pkg::US_NONE;
      end
      expect_content(b);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      pop3d_pkg::result_type want;
      if (reset) begin
         reply_st  = pop3d_pkg::STATE_RESET;
         multiline = 1'b0;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready)
            deframe_byte(req_in_byte);
         if (csr_wr_en)
            multiline = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected word, expected none, got %0h/%0d/%b/%b",
                        $time, rsp_out_byte, rsp_out_kind, rsp_response_ok, rsp_last);
            end else begin
               want = expected_words.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("out_kind", {6'd0, want.out_kind}, {6'd0, rsp_out_kind});
               check_field("response_ok", {7'd0, want.response_ok},
                           {7'd0, rsp_response_ok});
               check_field("last", {7'd0, want.last}, {7'd0, rsp_last});
            end
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

// ===== test/tb_pop3_response_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_pop3_response_deframer_core;

   localparam int ITEM_TARGET   = 1550;
   localparam int CALM_ITEMS    = 200;
   localparam int PHASE_ITEMS   = 150;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_out_kind;
   logic       rsp_response_ok;
   logic       rsp_last;
   int         mismatch_count;
   int         words_pending;

   bit         idling = 1'b1;
   bit         hold_rsp = 1'b0;
   bit         mode_now = 1'b0;
   int         bytes_sent = 0;
   logic [7:0] reply_bytes[$];

   always #4 clock = ~clock;

   pop3_response_deframer_core u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_response_ok (rsp_response_ok),
      .rsp_last        (rsp_last)
   );

   pop3_deframe_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_response_ok (rsp_response_ok),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   function automatic void add_byte(logic [7:0] b);
      reply_bytes.insert(reply_bytes.size(), b);
   endfunction

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic void push_text(int n);
      repeat (n) add_byte(text_byte());
   endfunction

   function automatic void push_str(string s);
      foreach (s[i]) add_byte(s[i]);
   endfunction

   function automatic void push_crlf();
      add_byte(pop3d_pkg::CH_CR);
      add_byte(pop3d_pkg::CH_LF);
   endfunction

   function automatic bit add_status_line();
      bit         is_err;
      string      head;
      logic [7:0] b;
      is_err = 1'b0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: head = "+OK";
         5, 6: begin
            head   = "-ERR";
            is_err = 1'b1;
         end
         7: begin
            if ($urandom_range(0, 1))
               head = "+O";
            else
               head = "-ER";
         end
         8: begin
            if ($urandom_range(0, 1))
               head = "+OK";
            else
               head = "-ERR";
            head[$urandom_range(0, head.len() - 1)] = 8'($urandom_range(33, 126));
         end
         default: head = "";
      endcase
      push_str(head);
      if ($urandom_range(0, 5) == 0)
         add_byte(pop3d_pkg::CH_LF);
      push_text($urandom_range(0, 12));
      // lone CR inside the status line
      if ($urandom_range(0, 7) == 0) begin
         add_byte(pop3d_pkg::CH_CR);
         b = text_byte();
         add_byte(b == pop3d_pkg::CH_LF ? 8'hFF : b);
      end
      push_crlf();
      return is_err;
   endfunction

   function automatic void add_body();
      int         lines;
      logic [7:0] b;
      lines = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      repeat (lines) begin
         case ($urandom_range(0, 7))
            0: begin
               push_str("..");
               push_text($urandom_range(0, 10));
            end
            1: begin
               push_str(".");
               add_byte(8'($urandom_range(33, 126)));
               push_text($urandom_range(0, 10));
            end
            2: begin
               push_str(".");
               add_byte(pop3d_pkg::CH_CR);
               b = text_byte();
               add_byte(b == pop3d_pkg::CH_LF ? 8'h00 : b);
               push_text($urandom_range(0, 6));
            end
            3: push_str("...");
            4: ;
            5: begin
               push_text($urandom_range(0, 6));
               add_byte($urandom_range(0, 1) ? pop3d_pkg::CH_CR : pop3d_pkg::CH_LF);
               push_text($urandom_range(0, 6));
            end
            default: push_text($urandom_range(1, 20));
         endcase
         push_crlf();
      end
      if ($urandom_range(0, 19) != 0) begin
         push_str(".");
         push_crlf();
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      bit rdy;
      if (bytes_sent >= ITEM_TARGET - CALM_ITEMS)
         idling = 1'b0;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      bytes_sent++;
   endtask

   task automatic send_reply();
      while (reply_bytes.size() > 0)
         send_byte(reply_bytes.pop_front());
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_now = m;
   endtask

   initial begin : rsp_side
      int span;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idling && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            span = $urandom_range(1, 14);
            repeat (span) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            span = idling ? $urandom_range(1, 20) : 1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      bit is_err;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-line OK with a bare LF in the status line
      push_str("+OK");
      add_byte(pop3d_pkg::CH_LF);
      push_crlf();
      send_reply();
      drain_words();

      // multi-line: doubled period, held CR without LF, lone period line
      write_mode(1'b1);
      push_str("+OK");
      push_crlf();
      push_str("..");
      add_byte(8'hFF);
      push_crlf();
      push_str(".");
      add_byte(pop3d_pkg::CH_CR);
      add_byte(8'h00);
      push_crlf();
      push_str(".");
      push_crlf();
      send_reply();
      drain_words();

      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         write_mode(phase % 3 != 1);
         if (phase == 2)
            hold_rsp = 1'b1;
         phase_end = bytes_sent + PHASE_ITEMS;
         while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET) begin
            is_err = add_status_line();
            if (mode_now && !is_err)
               add_body();
            send_reply();
         end
         // unfinished status line; the next mode write lands mid-reply
         if ($urandom_range(0, 1)) begin
            push_str("+OK");
            send_reply();
         end
         drain_words();
         phase++;
      end

      if (mismatch_count == 0 && words_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/pop3d_pkg.sv
hdl/pop3d_step.sv
hdl/pop3d_outq.sv
hdl/pop3_response_deframer_core.sv
hdl/pop3d_checker.sv
test/pop3_deframe_checker.sv
test/tb_pop3_response_deframer_core.sv
